>>> design/ntpc_pkg.sv
// Shared types, microcode encodings and calendar tables for the NTP date converter.
package ntpc_pkg;

    localparam int STEP_W = 4;

    localparam logic [31:0] NTP_UNIX_OFFSET = 32'd2208988800;
    localparam int          BASE_YEAR       = 1970;

    // datapath operations
    localparam logic [3:0] OP_IDLE        = 4'd0;
    localparam logic [3:0] OP_DIV         = 4'd1;
    localparam logic [3:0] OP_SPLIT_DAY   = 4'd2;
    localparam logic [3:0] OP_SPLIT_HOUR  = 4'd3;
    localparam logic [3:0] OP_SPLIT_MIN   = 4'd4;
    localparam logic [3:0] OP_SPLIT_QUAD  = 4'd5;
    localparam logic [3:0] OP_YEAR        = 4'd6;
    localparam logic [3:0] OP_MONTH       = 4'd7;
    localparam logic [3:0] OP_OUT         = 4'd8;
    localparam logic [3:0] OP_NOP         = 4'd9;

    // sequencing conditions
    localparam logic [1:0] C_NEXT      = 2'd0;  // always step + 1
    localparam logic [1:0] C_WAIT      = 2'd1;  // hold until go, then step + 1
    localparam logic [1:0] C_BRANCH    = 2'd2;  // go ? jump : step + 1
    localparam logic [1:0] C_WAIT_JUMP = 2'd3;  // hold until go, then jump

    // divisor select
    localparam logic [1:0] DV_DAY  = 2'd0;
    localparam logic [1:0] DV_HOUR = 2'd1;
    localparam logic [1:0] DV_MIN  = 2'd2;
    localparam logic [1:0] DV_QUAD = 2'd3;

    // program addresses
    localparam logic [STEP_W-1:0] ST_IDLE       = 4'd0;
    localparam logic [STEP_W-1:0] ST_DIV_DAY    = 4'd1;
    localparam logic [STEP_W-1:0] ST_SPLIT_DAY  = 4'd2;
    localparam logic [STEP_W-1:0] ST_DIV_HOUR   = 4'd3;
    localparam logic [STEP_W-1:0] ST_SPLIT_HOUR = 4'd4;
    localparam logic [STEP_W-1:0] ST_DIV_MIN    = 4'd5;
    localparam logic [STEP_W-1:0] ST_SPLIT_MIN  = 4'd6;
    localparam logic [STEP_W-1:0] ST_DIV_QUAD   = 4'd7;
    localparam logic [STEP_W-1:0] ST_SPLIT_QUAD = 4'd8;
    localparam logic [STEP_W-1:0] ST_YEAR       = 4'd9;
    localparam logic [STEP_W-1:0] ST_MONTH      = 4'd10;
    localparam logic [STEP_W-1:0] ST_OUT        = 4'd11;

    typedef struct packed {
        logic [3:0]        op;
        logic [1:0]        dsel;
        logic [1:0]        cond;
        logic [STEP_W-1:0] jmp;
    } uword_t;

    function automatic logic [16:0] divisor(input logic [1:0] sel);
        logic [16:0] d;
        unique case (sel)
            DV_DAY:  d = 17'd86400;
            DV_HOUR: d = 17'd3600;
            DV_MIN:  d = 17'd60;
            DV_QUAD: d = 17'd1461;
            default: d = 17'd86400;
        endcase
        return d;
    endfunction

    // reciprocal for the pre-shifted dividend of each divisor
    function automatic logic [25:0] recip(input logic [1:0] sel);
        logic [25:0] m;
        unique case (sel)
            DV_DAY:  m = 26'd50903317;  // (x >> 7) / 675, product >> 35
            DV_HOUR: m = 26'd9321;      // (x >> 4) / 225, product >> 21
            DV_MIN:  m = 26'd1093;      // (x >> 2) / 15,  product >> 14
            DV_QUAD: m = 26'd91868;     // x / 1461,       product >> 27
            default: m = 26'd50903317;
        endcase
        return m;
    endfunction

    // m is 0-based (0 = January)
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd0:  len = 5'd31;
            4'd1:  len = leap ? 5'd29 : 5'd28;
            4'd2:  len = 5'd31;
            4'd3:  len = 5'd30;
            4'd4:  len = 5'd31;
            4'd5:  len = 5'd30;
            4'd6:  len = 5'd31;
            4'd7:  len = 5'd31;
            4'd8:  len = 5'd30;
            4'd9:  len = 5'd31;
            4'd10: len = 5'd30;
            4'd11: len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> design/ntpc_ucode.sv
// Microprogram ROM: one control word per sequencer step.
module ntpc_ucode (
    input  logic [ntpc_pkg::STEP_W-1:0] step,
    output ntpc_pkg::uword_t            uw
);
    import ntpc_pkg::*;

    always_comb begin
        unique case (step)
            ST_IDLE:       uw = '{op: OP_IDLE,       dsel: DV_DAY,  cond: C_WAIT,   jmp: ST_IDLE};
            ST_DIV_DAY:    uw = '{op: OP_DIV,        dsel: DV_DAY,  cond: C_NEXT,   jmp: ST_IDLE};
            ST_SPLIT_DAY:  uw = '{op: OP_SPLIT_DAY,  dsel: DV_DAY,  cond: C_NEXT,   jmp: ST_IDLE};
            ST_DIV_HOUR:   uw = '{op: OP_DIV,        dsel: DV_HOUR, cond: C_NEXT,   jmp: ST_IDLE};
            ST_SPLIT_HOUR: uw = '{op: OP_SPLIT_HOUR, dsel: DV_HOUR, cond: C_NEXT,   jmp: ST_IDLE};
            ST_DIV_MIN:    uw = '{op: OP_DIV,        dsel: DV_MIN,  cond: C_NEXT,   jmp: ST_IDLE};
            // out-of-range dates skip the calendar walk
            ST_SPLIT_MIN:  uw = '{op: OP_SPLIT_MIN,  dsel: DV_MIN,  cond: C_BRANCH, jmp: ST_OUT};
            ST_DIV_QUAD:   uw = '{op: OP_DIV,        dsel: DV_QUAD, cond: C_NEXT,   jmp: ST_IDLE};
            ST_SPLIT_QUAD: uw = '{op: OP_SPLIT_QUAD, dsel: DV_QUAD, cond: C_NEXT,   jmp: ST_IDLE};
            ST_YEAR:       uw = '{op: OP_YEAR,       dsel: DV_DAY,  cond: C_WAIT,   jmp: ST_IDLE};
            ST_MONTH:      uw = '{op: OP_MONTH,      dsel: DV_DAY,  cond: C_WAIT,   jmp: ST_IDLE};
            ST_OUT:        uw = '{op: OP_OUT,        dsel: DV_DAY,  cond: C_WAIT_JUMP,
                                  jmp: ST_IDLE};
            default:       uw = '{op: OP_NOP,        dsel: DV_DAY,  cond: C_WAIT_JUMP,
                                  jmp: ST_IDLE};
        endcase
    end

endmodule

>>> design/ntpc_datapath.sv
// Datapath: reciprocal-multiply divider, year/month walk and output register.
module ntpc_datapath #(
    parameter int YEAR_LIMIT = 2038
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  ntpc_pkg::uword_t uw,
    output logic             go,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [31:0]      s_ntp_seconds,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [10:0]      m_year,
    output logic [3:0]       m_month,
    output logic [4:0]       m_day_of_month,
    output logic [4:0]       m_hour,
    output logic [5:0]       m_minute,
    output logic [5:0]       m_second,
    output logic             m_out_of_range
);
    import ntpc_pkg::*;

    // days from 1970-01-01 through the last day of YEAR_LIMIT-1
    localparam int DAYS_LIMIT = 365 * (YEAR_LIMIT - BASE_YEAR)
                              + ((YEAR_LIMIT - 1) / 4 - (BASE_YEAR - 1) / 4);

    logic [31:0] num_reg,  num_next;
    logic [15:0] quo_reg,  quo_next;
    logic [15:0] days_reg, days_next;
    logic [10:0] year_reg, year_next;
    logic [3:0]  mon_reg,  mon_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  min_reg,  min_next;
    logic [5:0]  sec_reg,  sec_next;
    logic        oor_reg,  oor_next;

    logic        m_valid_reg, m_valid_next;
    logic [10:0] m_year_reg,  m_year_next;
    logic [3:0]  m_month_reg, m_month_next;
    logic [4:0]  m_day_reg,   m_day_next;
    logic [4:0]  m_hour_reg,  m_hour_next;
    logic [5:0]  m_min_reg,   m_min_next;
    logic [5:0]  m_sec_reg,   m_sec_next;
    logic        m_oor_reg,   m_oor_next;

    logic [31:0] unix_s;
    logic [16:0] dv;
    logic [24:0] mul_a;
    logic [25:0] mul_b;
    logic [50:0] q_prod;     // 25 x 26 bit product
    logic [15:0] q_sel;
    logic [16:0] back_prod;
    logic [16:0] rem_now;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;

    assign unix_s    = s_ntp_seconds - NTP_UNIX_OFFSET;
    assign dv        = divisor(uw.dsel);
    assign mul_b     = recip(uw.dsel);
    assign q_prod    = 51'(mul_a) * 51'(mul_b);
    // remainders are below 2^17, so the low bits of the multiply-back suffice
    assign back_prod = {1'b0, quo_reg} * dv;
    assign rem_now   = num_reg[16:0] - back_prod;
    assign leap      = (year_reg[1:0] == 2'b00);
    assign ylen      = leap ? 9'd366 : 9'd365;
    assign mlen      = month_len(mon_reg, leap);

    assign s_ready = (uw.op == OP_IDLE);

    // dividend alignment and quotient pick for each divisor
    always_comb begin
        unique case (uw.dsel)
            DV_DAY: begin
                mul_a = num_reg[31:7];
                q_sel = q_prod[50:35];
            end
            DV_HOUR: begin
                mul_a = {12'd0, num_reg[16:4]};
                q_sel = {11'd0, q_prod[25:21]};
            end
            DV_MIN: begin
                mul_a = {15'd0, num_reg[11:2]};
                q_sel = {10'd0, q_prod[19:14]};
            end
            DV_QUAD: begin
                mul_a = {9'd0, num_reg[15:0]};
                q_sel = {10'd0, q_prod[32:27]};
            end
            default: begin
                mul_a = num_reg[31:7];
                q_sel = q_prod[50:35];
            end
        endcase
    end

    always_comb begin
        num_next     = num_reg;
        quo_next     = quo_reg;
        days_next    = days_reg;
        year_next    = year_reg;
        mon_next     = mon_reg;
        hour_next    = hour_reg;
        min_next     = min_reg;
        sec_next     = sec_reg;
        oor_next     = oor_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        m_year_next  = m_year_reg;
        m_month_next = m_month_reg;
        m_day_next   = m_day_reg;
        m_hour_next  = m_hour_reg;
        m_min_next   = m_min_reg;
        m_sec_next   = m_sec_reg;
        m_oor_next   = m_oor_reg;
        go           = 1'b1;

        unique case (uw.op)
            OP_IDLE: begin
                go = s_valid;
                if (s_valid) begin
                    num_next = unix_s;
                end
            end
            OP_DIV: begin
                quo_next = q_sel;
            end
            OP_SPLIT_DAY: begin
                days_next = quo_reg;
                oor_next  = ({1'b0, quo_reg} >= 17'(DAYS_LIMIT));
                num_next  = {15'd0, rem_now};
            end
            OP_SPLIT_HOUR: begin
                hour_next = quo_reg[4:0];
                num_next  = {15'd0, rem_now};
            end
            OP_SPLIT_MIN: begin
                min_next = quo_reg[5:0];
                sec_next = rem_now[5:0];
                go       = oor_reg;
                if (oor_reg) begin
                    year_next = 11'(YEAR_LIMIT - 1);
                    mon_next  = 4'd11;
                    days_next = 16'd30;
                end else begin
                    num_next = {16'd0, days_reg};
                end
            end
            OP_SPLIT_QUAD: begin
                year_next = 11'(BASE_YEAR) + {3'd0, quo_reg[5:0], 2'b00};
                days_next = {5'd0, rem_now[10:0]};
                mon_next  = 4'd0;
            end
            OP_YEAR: begin
                go = (days_reg < {7'd0, ylen});
                if (!go) begin
                    days_next = days_reg - {7'd0, ylen};
                    year_next = year_reg + 11'd1;
                end
            end
            OP_MONTH: begin
                go = (mon_reg == 4'd11) || (days_reg < {11'd0, mlen});
                if (!go) begin
                    days_next = days_reg - {11'd0, mlen};
                    mon_next  = mon_reg + 4'd1;
                end
            end
            OP_OUT: begin
                go = ~m_valid_reg | m_ready;
                if (go) begin
                    m_valid_next = 1'b1;
                    m_year_next  = year_reg;
                    m_month_next = mon_reg + 4'd1;
                    m_day_next   = days_reg[4:0] + 5'd1;
                    m_hour_next  = hour_reg;
                    m_min_next   = min_reg;
                    m_sec_next   = sec_reg;
                    m_oor_next   = oor_reg;
                end
            end
            default: begin
                go = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg     <= num_next;
        quo_reg     <= quo_next;
        days_reg    <= days_next;
        year_reg    <= year_next;
        mon_reg     <= mon_next;
        hour_reg    <= hour_next;
        min_reg     <= min_next;
        sec_reg     <= sec_next;
        oor_reg     <= oor_next;
        m_year_reg  <= m_year_next;
        m_month_reg <= m_month_next;
        m_day_reg   <= m_day_next;
        m_hour_reg  <= m_hour_next;
        m_min_reg   <= m_min_next;
        m_sec_reg   <= m_sec_next;
        m_oor_reg   <= m_oor_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_year         = m_year_reg;
    assign m_month        = m_month_reg;
    assign m_day_of_month = m_day_reg;
    assign m_hour         = m_hour_reg;
    assign m_minute       = m_min_reg;
    assign m_second       = m_sec_reg;
    assign m_out_of_range = m_oor_reg;

endmodule

>>> design/ntp_seconds_to_calendar_date.sv
// Top level: NTP seconds to UTC calendar date and time of day, microcoded.
//
// Usage: s_valid/s_ready carries one item, a 32-bit NTP seconds count;
//   m_valid/m_ready carries one result item per input: year, month,
//   day_of_month, hour, minute, second and out_of_range. Dates past Dec 31
//   of YEAR_LIMIT-1 (most pre-1970 times wrap there too) set out_of_range and
//   saturate the date at YEAR_LIMIT-1-12-31; the time of day is always valid.
// Timing: one item at a time; s_ready is high only at the idle step.
//   Out-of-range dates skip the calendar walk; the next item can be taken
//   at the idle step right after the result is registered. Each split
//   (days, hours, minutes, 4-year groups) is a reciprocal multiply for
//   the quotient, then a multiply-back for the remainder. Then comes a
//   walk that takes off whole years, then whole months, from the days.
// Stall: the result sits in an output register and the next item is
//   accepted while it waits. If a new result finishes while m_ready is
//   still low, the sequencer holds at its output step until it frees up.
// Reset: aresetn (synchronous, active low) returns the sequencer to idle
//   and drops m_valid. No other state to clear.
module ntp_seconds_to_calendar_date #(
    parameter int YEAR_LIMIT = 2038
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_ntp_seconds,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [10:0] m_year,
    output logic [3:0]  m_month,
    output logic [4:0]  m_day_of_month,
    output logic [4:0]  m_hour,
    output logic [5:0]  m_minute,
    output logic [5:0]  m_second,
    output logic        m_out_of_range
);
    import ntpc_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    uword_t            uw;
    logic              go;

    // control store
    ntpc_ucode u_ucode (
        .step (step_reg),
        .uw   (uw)
    );

    // step counter with conditional jumps; go comes back from the datapath
    always_comb begin
        unique case (uw.cond)
            C_NEXT:      step_next = step_reg + 4'd1;
            C_WAIT:      step_next = go ? step_reg + 4'd1 : step_reg;
            C_BRANCH:    step_next = go ? uw.jmp : step_reg + 4'd1;
            C_WAIT_JUMP: step_next = go ? uw.jmp : step_reg;
            default:     step_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    ntpc_datapath #(
        .YEAR_LIMIT (YEAR_LIMIT)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .uw             (uw),
        .go             (go),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_ntp_seconds  (s_ntp_seconds),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_year         (m_year),
        .m_month        (m_month),
        .m_day_of_month (m_day_of_month),
        .m_hour         (m_hour),
        .m_minute       (m_minute),
        .m_second       (m_second),
        .m_out_of_range (m_out_of_range)
    );

endmodule

>>> dv/ntp_seconds_to_calendar_date_test.sv
// Self-checking testbench for the NTP seconds to calendar date converter.
`timescale 1ns / 1ps

module ntp_seconds_to_calendar_date_test;

    import ntpc_pkg::*;

    localparam int          YEAR_LIMIT  = 2038;
    localparam int unsigned SECS_IN_DAY = 86400;
    localparam int          N_RANDOM    = 1030;
    localparam int          CALM_TAIL   = 150;   // last items run with no idling
    localparam int          HOLD_AT     = 300;   // results seen before the long stall
    localparam int          HOLD_CYCLES = 400;
    localparam int          DRAIN_WAIT  = 100;   // covers the worst-case latency

    localparam int unsigned CAL_MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    // one decoded date, as the result channel carries it
    typedef struct {
        logic [10:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        past_limit;
    } cal_date_t;

    logic        aclk;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [31:0] s_ntp_seconds  = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [10:0] m_year;
    logic [3:0]  m_month;
    logic [4:0]  m_day_of_month;
    logic [4:0]  m_hour;
    logic [5:0]  m_minute;
    logic [5:0]  m_second;
    logic        m_out_of_range;

    logic [31:0] ntp_to_send [$];   // items waiting for the driver
    cal_date_t   dates_due [$];     // predicted dates, oldest first

    int n_total        = 0;
    int n_presented    = 0;
    int n_accepted     = 0;
    int n_results      = 0;
    int n_past_limit   = 0;
    int n_errors       = 0;
    int n_stall_cycles = 0;
    int send_gap       = 0;
    int recv_gap       = 0;
    logic hold_off     = 1'b0;

    ntp_seconds_to_calendar_date #(
        .YEAR_LIMIT(YEAR_LIMIT)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_ntp_seconds  (s_ntp_seconds),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_year         (m_year),
        .m_month        (m_month),
        .m_day_of_month (m_day_of_month),
        .m_hour         (m_hour),
        .m_minute       (m_minute),
        .m_second       (m_second),
        .m_out_of_range (m_out_of_range)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Days from 1970-01-01 to Jan 1 of year y; every fourth year is a leap year.
    function automatic int unsigned days_before(input int unsigned y);
        return (y - 1970) * 365 + (y - 1969) / 4;
    endfunction

    // NTP seconds for a 0-based day since 1970 and a second within that day.
    function automatic logic [31:0] ntp_at(input int unsigned day, input int unsigned tod);
        logic [31:0] unix_s;
        unix_s = day * SECS_IN_DAY + tod;
        return unix_s + NTP_UNIX_OFFSET;
    endfunction

    // Date and time of day for one NTP seconds count.
    function automatic cal_date_t calendar_of_ntp(input logic [31:0] ntp);
        cal_date_t   r;
        logic [31:0] unix_s;
        int unsigned tod;
        int unsigned days;
        int unsigned yr;
        int unsigned ylen;
        int unsigned mo;
        int unsigned mlen;
        bit          hit;
        bit          mo_done;
        unix_s = ntp - NTP_UNIX_OFFSET;          // wraps for pre-1970 times
        tod    = unix_s % 32'd86400;
        days   = unix_s / 32'd86400;
        yr     = BASE_YEAR;
        hit    = 1'b0;
        while (yr < YEAR_LIMIT && !hit) begin
            ylen = (yr % 4 == 0) ? 366 : 365;
            if (days < ylen) begin
                hit = 1'b1;
            end else begin
                days -= ylen;
                yr++;
            end
        end
        if (hit) begin
            mo      = 0;
            mo_done = 1'b0;
            while (mo < 11 && !mo_done) begin
                mlen = CAL_MONTH_LEN[mo] + ((mo == 1 && yr % 4 == 0) ? 1 : 0);
                if (days < mlen) begin
                    mo_done = 1'b1;
                end else begin
                    days -= mlen;
                    mo++;
                end
            end
            r.year  = 11'(yr);
            r.month = 4'(mo + 1);
            r.mday  = 5'(days + 1);
        end else begin
            // saturated date
            r.year  = 11'(YEAR_LIMIT - 1);
            r.month = 4'd12;
            r.mday  = 5'd31;
        end
        r.hour       = 5'(tod / 3600);
        r.minute     = 6'((tod % 3600) / 60);
        r.second     = 6'(tod % 60);
        r.past_limit = !hit;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("ERROR t=%0t %s: expected %0d, got %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    // Driver: presents queued items, holds each until accepted, then may idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                dates_due.push_back(calendar_of_ntp(s_ntp_seconds));
                n_accepted++;
            end
            if (s_valid && !s_ready && hold_off)
                n_stall_cycles++;
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (ntp_to_send.size() > 0) begin
                    s_valid       <= 1'b1;
                    s_ntp_seconds <= ntp_to_send.pop_front();
                    n_presented++;
                    // idle burst after this item, none in the calm tail
                    if (n_presented < n_total - CALM_TAIL && $urandom_range(0, 7) == 0)
                        send_gap <= $urandom_range(1, 15);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (dates_due.size() == 0) begin
                    $display("ERROR t=%0t result with no item pending: %0d-%0d-%0d",
                             $time, m_year, m_month, m_day_of_month);
                    n_errors++;
                end else begin
                    cal_date_t want;
                    want = dates_due.pop_front();
                    if (want.past_limit)
                        n_past_limit++;
                    check_field("year",         want.year,       m_year);
                    check_field("month",        want.month,      m_month);
                    check_field("day_of_month", want.mday,       m_day_of_month);
                    check_field("hour",         want.hour,       m_hour);
                    check_field("minute",       want.minute,     m_minute);
                    check_field("second",       want.second,     m_second);
                    check_field("out_of_range", want.past_limit, m_out_of_range);
                end
            end
            if (hold_off) begin
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready  <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (n_results < n_total - CALM_TAIL && $urandom_range(0, 15) == 0)
                    recv_gap <= $urandom_range(1, 15);
            end
        end
    end

    // Long back-pressure: output register and sequencer fill, s_ready drops.
    initial begin
        while (n_results < HOLD_AT) @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // Run limit: a timeout with ample margin for all ~1100 items.
    initial begin
        #6_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int unsigned day;
        int unsigned yr;
        int unsigned pick;
        int unsigned lim_s;

        // --- directed items ---
        ntp_to_send.push_back(32'h0000_0000);                         // 1900, wraps to a date in 2036
        ntp_to_send.push_back(32'hFFFF_FFFF);                         // all ones
        ntp_to_send.push_back(ntp_at(0, 0));                          // epoch start
        ntp_to_send.push_back(NTP_UNIX_OFFSET - 32'd1);               // last second of 1969
        ntp_to_send.push_back(ntp_at(0, SECS_IN_DAY - 1));            // end of first day
        ntp_to_send.push_back(ntp_at(364, 43200));                    // 1970-12-31 noon
        ntp_to_send.push_back(ntp_at(days_before(1972) - 1, SECS_IN_DAY - 1));
        ntp_to_send.push_back(ntp_at(days_before(1972) + 58, 0));     // Feb 28 of a leap year
        ntp_to_send.push_back(ntp_at(days_before(1972) + 59, 45296)); // leap day 12:34:56
        ntp_to_send.push_back(ntp_at(days_before(1972) + 60, 0));     // Mar 1
        ntp_to_send.push_back(ntp_at(days_before(1973), 0));          // year after a leap year
        ntp_to_send.push_back(ntp_at(days_before(2000) + 59, 3599));  // 2000 still leaps
        ntp_to_send.push_back(ntp_at(days_before(2036) + 365, 60));   // Dec 31 of a leap year
        ntp_to_send.push_back(ntp_at(days_before(2037) + 58, 59));    // Feb 28, common year
        ntp_to_send.push_back(ntp_at(days_before(YEAR_LIMIT) - 1, SECS_IN_DAY - 1)); // last valid
        ntp_to_send.push_back(ntp_at(days_before(YEAR_LIMIT), 0));    // first date past limit
        ntp_to_send.push_back(32'hFFFF_FFFF + NTP_UNIX_OFFSET);       // largest unix count
        ntp_to_send.push_back(32'h8000_0000);
        ntp_to_send.push_back(32'h7FFF_FFFF);

        // --- random items: mostly dates in range, with edges and noise ---
        lim_s = days_before(YEAR_LIMIT) * SECS_IN_DAY;
        for (int i = 0; i < N_RANDOM; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                ntp_to_send.push_back(ntp_at($urandom_range(0, days_before(YEAR_LIMIT) - 1),
                                             $urandom_range(0, SECS_IN_DAY - 1)));
            end else if (pick < 72) begin
                // any day of a random year, at the first or last second of the day
                yr  = $urandom_range(1970, YEAR_LIMIT - 1);
                day = days_before(yr) + $urandom_range(0, 365);
                if (day >= days_before(YEAR_LIMIT))
                    day = days_before(YEAR_LIMIT) - 1;
                ntp_to_send.push_back(ntp_at(day, $urandom_range(0, 1) ? SECS_IN_DAY - 1 : 0));
            end else if (pick < 85) begin
                // close to the last valid second
                ntp_to_send.push_back(lim_s + $urandom_range(0, 400000) - 200000
                                      + NTP_UNIX_OFFSET);
            end else begin
                ntp_to_send.push_back($urandom());
            end
        end
        n_total = ntp_to_send.size();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (n_accepted < n_total) @(posedge aclk);
        while (dates_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);   // catch any stray extra result

        $display("Checked %0d results over %0d items, %0d of them past the date limit",
                 n_results, n_total, n_past_limit);
        $display("Input stalled %0d cycles while the output was held off", n_stall_cycles);
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
design/ntpc_pkg.sv
design/ntpc_ucode.sv
design/ntpc_datapath.sv
design/ntp_seconds_to_calendar_date.sv
dv/ntp_seconds_to_calendar_date_test.sv
